### design/thb_pkg.sv
// Shared types, constants and helpers for the thread heartbeat registry.
// Depends on nothing; thb_ctrl and the top level import it.
package thb_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;

  localparam int REQ_W  = 3;
  localparam int PROC_W = 22;
  localparam int THR_W  = 22;
  localparam int HND_W  = 16;
  localparam int BEAT_W = 63;
  localparam int ADDR_W = 64;
  localparam int LIM_W  = 32;
  localparam int SEL_W  = 6;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD          = 3'd0,
    REQ_BEAT         = 3'd1,
    REQ_WAIT         = 3'd2,
    REQ_ACQ          = 3'd3,
    REQ_REMOVE       = 3'd4,
    REQ_CLEAN_PROC   = 3'd5,
    REQ_CLEAN_HANDLE = 3'd6,
    REQ_READ         = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_RMW,
    S_RD_ISSUE,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic [THR_W-1:0]  thread;
    logic [HND_W-1:0]  handle;
  } key_t;

  typedef struct packed {
    logic [BEAT_W-1:0] beat;
    logic [ADDR_W-1:0] wait_addr;
    logic [LIM_W-1:0]  gap;
    logic [LIM_W-1:0]  hold;
  } data_t;

  localparam int KEY_W  = $bits(key_t);
  localparam int DATA_W = $bits(data_t);

  typedef struct packed {
    logic              re;
    logic              key_we;
    logic              data_we;
    logic [SLOT_W-1:0] addr;
  } ram_ctl_t;

  typedef struct packed {
    logic             fire;
    status_t          status;
    logic [SEL_W-1:0] slot;
    logic             active;
  } result_t;

  function automatic logic [SEL_W-1:0] idx_to_slot(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SEL_W-1:0] wide;
    wide = {{SEL_W{1'b0}}, idx};
    return wide[SEL_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] sel_to_idx(input logic [SEL_W-1:0] sel);
    logic [SLOT_W+SEL_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, sel};
    return wide[SLOT_W-1:0];
  endfunction

  function automatic logic sel_in_range(input logic [SEL_W-1:0] sel);
    return 32'(sel) < SLOTS;
  endfunction

endpackage

### design/thb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module thb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/thb_ctrl.sv
// Request sequencer: slot scan, valid flags, match bookkeeping, RAM control.
// Depends on thb_pkg.
module thb_ctrl import thb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start_acc,
  input  req_t              req_in,
  input  logic [PROC_W-1:0] proc,
  input  logic [THR_W-1:0]  thread,
  input  logic [HND_W-1:0]  handle,
  input  logic [SEL_W-1:0]  sel,
  input  key_t              key_rd,
  output ram_ctl_t          ram,
  output result_t           res,
  output logic              busy
);

  state_t            state, state_next;
  req_t              req_q, req_q_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              pipe_vld, pipe_vld_next;
  logic [SLOT_W-1:0] pipe_idx, pipe_idx_next;
  logic              hit_found, hit_found_next;
  logic [SLOT_W-1:0] hit_idx, hit_idx_next;
  logic              free_found, free_found_next;
  logic [SLOT_W-1:0] free_idx, free_idx_next;
  logic [SLOTS-1:0]  valid, valid_next;

  logic cur_valid;
  logic proc_eq;

  assign busy      = (state != S_IDLE);
  assign cur_valid = valid[pipe_idx];
  assign proc_eq   = (key_rd.proc == proc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    cnt        <= cnt_next;
    pipe_vld   <= pipe_vld_next;
    pipe_idx   <= pipe_idx_next;
    hit_found  <= hit_found_next;
    hit_idx    <= hit_idx_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
  end

  always_comb begin
    state_next      = state;
    req_q_next      = req_q;
    cnt_next        = cnt;
    pipe_vld_next   = pipe_vld;
    pipe_idx_next   = pipe_idx;
    hit_found_next  = hit_found;
    hit_idx_next    = hit_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    valid_next      = valid;
    ram             = '0;
    ram.addr        = cnt[SLOT_W-1:0];
    res             = '0;
    res.status      = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (start_acc) begin
          req_q_next      = req_in;
          cnt_next        = '0;
          pipe_vld_next   = 1'b0;
          hit_found_next  = 1'b0;
          free_found_next = 1'b0;
          state_next      = (req_in == REQ_READ) ? S_RD_ISSUE : S_SCAN;
        end
      end

      S_SCAN: begin
        // issue stage: read the next slot's key
        if (cnt < CNT_W'(SLOTS)) begin
          ram.re        = 1'b1;
          ram.addr      = cnt[SLOT_W-1:0];
          cnt_next      = cnt + CNT_W'(1);
          pipe_vld_next = 1'b1;
          pipe_idx_next = cnt[SLOT_W-1:0];
        end else begin
          pipe_vld_next = 1'b0;
          if (pipe_vld) begin
            state_next = S_FIN;
          end
        end
        // compare stage: key of pipe_idx is on key_rd
        if (pipe_vld) begin
          if (cur_valid && proc_eq && key_rd.thread == thread && !hit_found) begin
            hit_found_next = 1'b1;
            hit_idx_next   = pipe_idx;
          end
          if (!cur_valid && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = pipe_idx;
          end
          if (req_q == REQ_CLEAN_PROC && cur_valid && proc_eq) begin
            valid_next[pipe_idx] = 1'b0;
          end
          if (req_q == REQ_CLEAN_HANDLE && cur_valid && key_rd.handle == handle) begin
            valid_next[pipe_idx] = 1'b0;
          end
        end
      end

      S_FIN: begin
        state_next = S_IDLE;
        res.fire   = 1'b1;
        unique case (req_q)
          REQ_ADD: begin
            if (hit_found) begin
              res.status = ST_DUP;
              res.slot   = idx_to_slot(hit_idx);
            end else if (free_found) begin
              ram.addr             = free_idx;
              ram.key_we           = 1'b1;
              ram.data_we          = 1'b1;
              valid_next[free_idx] = 1'b1;
              res.slot             = idx_to_slot(free_idx);
            end else begin
              res.status = ST_FULL;
            end
          end
          REQ_BEAT, REQ_WAIT, REQ_ACQ: begin
            if (hit_found) begin
              // fetch the data word, patch it next cycle
              res.fire   = 1'b0;
              ram.re     = 1'b1;
              ram.addr   = hit_idx;
              state_next = S_RMW;
            end else begin
              res.status = ST_NONE;
            end
          end
          REQ_REMOVE: begin
            if (hit_found) begin
              valid_next[hit_idx] = 1'b0;
              res.slot            = idx_to_slot(hit_idx);
            end else begin
              res.status = ST_NONE;
            end
          end
          REQ_CLEAN_PROC, REQ_CLEAN_HANDLE: begin
            res.status = ST_OK;
          end
          REQ_READ: begin
            res.status = ST_NONE;
          end
        endcase
      end

      S_RMW: begin
        ram.addr    = hit_idx;
        ram.data_we = 1'b1;
        res.fire    = 1'b1;
        res.slot    = idx_to_slot(hit_idx);
        state_next  = S_IDLE;
      end

      S_RD_ISSUE: begin
        ram.addr   = sel_to_idx(sel);
        ram.re     = sel_in_range(sel);
        state_next = S_RD_OUT;
      end

      S_RD_OUT: begin
        res.fire   = 1'b1;
        res.slot   = sel;
        state_next = S_IDLE;
        if (sel_in_range(sel)) begin
          res.active = valid[sel_to_idx(sel)];
        end else begin
          res.status = ST_NONE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // an add writes key and data words together; nothing else writes the key
  a_key_with_data: assert property (@(posedge clk) disable iff (rst)
    ram.key_we |-> ram.data_we && req_q == REQ_ADD)
    else $error("key write without matching data write");

  // a reported full table really has every slot taken
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    res.fire && res.status == ST_FULL |-> &valid)
    else $error("table full reported with a free slot");

  // one result per request, then back to idle
  a_fire_then_idle: assert property (@(posedge clk) disable iff (rst)
    res.fire |=> state == S_IDLE && !$past(start_acc))
    else $error("result not followed by idle");

  // an accepted request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> busy && !res.fire)
    else $error("accepted request left controller idle");

  // no read and write of the data RAM in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram.re && ram.data_we))
    else $error("data RAM read and written together");

endmodule

### design/thread_heartbeat_registry_top.sv
// Top level of the thread heartbeat registry: request capture, slot RAMs,
// data word patching and result registers. Depends on thb_pkg, thb_ram, thb_ctrl.
module thread_heartbeat_registry_top import thb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [PROC_W-1:0] proc_id,
  input  logic [THR_W-1:0]  thread_id,
  input  logic [HND_W-1:0]  client_handle,
  input  logic [BEAT_W-1:0] stamp_ns,
  input  logic [ADDR_W-1:0] wait_address,
  input  logic [LIM_W-1:0]  gap_limit_ms,
  input  logic [LIM_W-1:0]  hold_limit_ms,
  input  logic [SEL_W-1:0]  slot_select,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [SEL_W-1:0]  slot,
  output logic              entry_active,
  output logic [PROC_W-1:0] entry_proc,
  output logic [THR_W-1:0]  entry_thread,
  output logic [HND_W-1:0]  entry_handle,
  output logic [BEAT_W-1:0] entry_beat_ns,
  output logic [ADDR_W-1:0] entry_wait_addr,
  output logic [LIM_W-1:0]  entry_gap_ms,
  output logic [LIM_W-1:0]  entry_hold_ms
);

  // Table requests walk every slot, one key read per cycle, before done rises;
  // heartbeat, lock wait and lock acquired on a hit then pass through a
  // read-modify-write state (S_RMW). Read slot issues its read in S_RD_ISSUE
  // and reports from S_RD_OUT; no new request is taken until the controller is idle.
  // One request is in flight at a time: a new beat is taken while done is high.
  // Reset clears the state machine and the per-slot active flags at once;
  // the key and data RAMs are not cleared, and no clearing pass runs.
  // Each result is presented on done for exactly one cycle; the receiver
  // cannot stall it.

  logic     start_acc;
  req_t     req_q;
  key_t     key_q;
  logic [BEAT_W-1:0] stamp_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LIM_W-1:0]  gap_q;
  logic [LIM_W-1:0]  hold_q;
  logic [SEL_W-1:0]  sel_q;

  ram_ctl_t ram;
  result_t  res;
  key_t     key_rd;
  data_t    data_rd;
  data_t    data_wr;

  assign start_acc = start && !busy;

  // capture the request beat; held for the whole scan
  always_ff @(posedge clk) begin
    if (start_acc) begin
      req_q        <= req_t'(req_type);
      key_q.proc   <= proc_id;
      key_q.thread <= thread_id;
      key_q.handle <= client_handle;
      stamp_q      <= stamp_ns;
      addr_q       <= wait_address;
      gap_q        <= gap_limit_ms;
      hold_q       <= hold_limit_ms;
      sel_q        <= slot_select;
    end
  end

  thb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start_acc (start_acc),
    .req_in    (req_t'(req_type)),
    .proc      (key_q.proc),
    .thread    (key_q.thread),
    .handle    (key_q.handle),
    .sel       (sel_q),
    .key_rd    (key_rd),
    .ram       (ram),
    .res       (res),
    .busy      (busy)
  );

  // patch the fetched data word, or build a fresh one on add
  always_comb begin
    data_wr = data_rd;
    unique case (req_q)
      REQ_ADD: begin
        data_wr.beat      = '0;
        data_wr.wait_addr = '0;
        data_wr.gap       = gap_q;
        data_wr.hold      = hold_q;
      end
      REQ_BEAT: data_wr.beat      = stamp_q;
      REQ_WAIT: data_wr.wait_addr = addr_q;
      REQ_ACQ:  data_wr.wait_addr = '0;
      REQ_REMOVE, REQ_CLEAN_PROC, REQ_CLEAN_HANDLE, REQ_READ: begin
        data_wr = data_rd;
      end
    endcase
  end

  thb_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (ram.key_we),
    .waddr (ram.addr),
    .wdata (key_q),
    .re    (ram.re),
    .raddr (ram.addr),
    .rdata (key_rd)
  );

  thb_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (ram.data_we),
    .waddr (ram.addr),
    .wdata (data_wr),
    .re    (ram.re),
    .raddr (ram.addr),
    .rdata (data_rd)
  );

  // result strobe: one cycle per request
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.fire;
    end
  end

  // result payload; entry fields are zero unless a live slot was read
  always_ff @(posedge clk) begin
    if (res.fire) begin
      status          <= res.status;
      slot            <= res.slot;
      entry_active    <= res.active;
      entry_proc      <= res.active ? key_rd.proc       : '0;
      entry_thread    <= res.active ? key_rd.thread     : '0;
      entry_handle    <= res.active ? key_rd.handle     : '0;
      entry_beat_ns   <= res.active ? data_rd.beat      : '0;
      entry_wait_addr <= res.active ? data_rd.wait_addr : '0;
      entry_gap_ms    <= res.active ? data_rd.gap       : '0;
      entry_hold_ms   <= res.active ? data_rd.hold      : '0;
    end
  end

endmodule

### dv/thb_registry_checker.sv
// Checker for the thread heartbeat registry: keeps its own copy of the slot table,
// predicts the answer to every accepted request and compares each result beat.
// Depends on thb_pkg.
module thb_registry_checker import thb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [PROC_W-1:0] proc_id,
  input  logic [THR_W-1:0]  thread_id,
  input  logic [HND_W-1:0]  client_handle,
  input  logic [BEAT_W-1:0] stamp_ns,
  input  logic [ADDR_W-1:0] wait_address,
  input  logic [LIM_W-1:0]  gap_limit_ms,
  input  logic [LIM_W-1:0]  hold_limit_ms,
  input  logic [SEL_W-1:0]  slot_select,
  input  logic              done,
  input  logic [STAT_W-1:0] status,
  input  logic [SEL_W-1:0]  slot,
  input  logic              entry_active,
  input  logic [PROC_W-1:0] entry_proc,
  input  logic [THR_W-1:0]  entry_thread,
  input  logic [HND_W-1:0]  entry_handle,
  input  logic [BEAT_W-1:0] entry_beat_ns,
  input  logic [ADDR_W-1:0] entry_wait_addr,
  input  logic [LIM_W-1:0]  entry_gap_ms,
  input  logic [LIM_W-1:0]  entry_hold_ms,
  output int                fault_count,
  output int                answers_owed
);

  typedef struct packed {
    status_t           status;
    logic [SEL_W-1:0]  slot;
    logic              active;
    logic [PROC_W-1:0] proc;
    logic [THR_W-1:0]  thread;
    logic [HND_W-1:0]  handle;
    logic [BEAT_W-1:0] beat;
    logic [ADDR_W-1:0] wait_addr;
    logic [LIM_W-1:0]  gap;
    logic [LIM_W-1:0]  hold;
  } answer_t;

  answer_t owed_q[$];

  logic              tab_live   [SLOTS];
  logic [PROC_W-1:0] tab_proc   [SLOTS];
  logic [THR_W-1:0]  tab_thread [SLOTS];
  logic [HND_W-1:0]  tab_handle [SLOTS];
  logic [BEAT_W-1:0] tab_beat   [SLOTS];
  logic [ADDR_W-1:0] tab_wait   [SLOTS];
  logic [LIM_W-1:0]  tab_gap    [SLOTS];
  logic [LIM_W-1:0]  tab_hold   [SLOTS];

  initial begin
    fault_count  = 0;
    answers_owed = 0;
  end

  function automatic int find_thread(input logic [PROC_W-1:0] p,
                                     input logic [THR_W-1:0] t);
    int i;
    for (i = 0; i < SLOTS; i++)
      if (tab_live[i] && tab_proc[i] == p && tab_thread[i] == t) return i;
    return -1;
  endfunction

  // Apply one request to the table copy and build the answer it must produce.
  task automatic apply_request(input req_t rq, input logic [PROC_W-1:0] p,
                               input logic [THR_W-1:0] t, input logic [HND_W-1:0] h,
                               input logic [BEAT_W-1:0] stamp, input logic [ADDR_W-1:0] addr,
                               input logic [LIM_W-1:0] gap, input logic [LIM_W-1:0] hold,
                               input logic [SEL_W-1:0] sel, output answer_t a);
    int k;
    int fr;
    int i;
    a = '0;
    a.status = ST_OK;
    k = find_thread(p, t);
    case (rq)
      REQ_ADD: begin
        if (k >= 0) begin
          a.status = ST_DUP;
          a.slot   = SEL_W'(k);
        end else begin
          fr = -1;
          for (i = 0; i < SLOTS; i++)
            if (!tab_live[i] && fr < 0) fr = i;
          if (fr < 0) begin
            a.status = ST_FULL;
          end else begin
            tab_live[fr]   = 1'b1;
            tab_proc[fr]   = p;
            tab_thread[fr] = t;
            tab_handle[fr] = h;
            tab_beat[fr]   = '0;
            tab_wait[fr]   = '0;
            tab_gap[fr]    = gap;
            tab_hold[fr]   = hold;
            a.slot         = SEL_W'(fr);
          end
        end
      end
      REQ_BEAT, REQ_WAIT, REQ_ACQ, REQ_REMOVE: begin
        if (k < 0) begin
          a.status = ST_NONE;
        end else begin
          a.slot = SEL_W'(k);
          case (rq)
            REQ_BEAT: tab_beat[k] = stamp;
            REQ_WAIT: tab_wait[k] = addr;
            REQ_ACQ:  tab_wait[k] = '0;
            default:  tab_live[k] = 1'b0;
          endcase
        end
      end
      REQ_CLEAN_PROC: begin
        for (i = 0; i < SLOTS; i++)
          if (tab_live[i] && tab_proc[i] == p) tab_live[i] = 1'b0;
      end
      REQ_CLEAN_HANDLE: begin
        for (i = 0; i < SLOTS; i++)
          if (tab_live[i] && tab_handle[i] == h) tab_live[i] = 1'b0;
      end
      default: begin
        a.slot = sel;
        if (32'(sel) >= SLOTS) begin
          a.status = ST_NONE;
        end else if (tab_live[sel]) begin
          a.active    = 1'b1;
          a.proc      = tab_proc[sel];
          a.thread    = tab_thread[sel];
          a.handle    = tab_handle[sel];
          a.beat      = tab_beat[sel];
          a.wait_addr = tab_wait[sel];
          a.gap       = tab_gap[sel];
          a.hold      = tab_hold[sel];
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    answer_t fresh;
    int i;
    if (rst) begin
      for (i = 0; i < SLOTS; i++) tab_live[i] = 1'b0;
      owed_q.delete();
    end else begin
      // retire the result beat first: it always belongs to an older request
      if (done) begin
        if (owed_q.size() == 0) begin
          $error("result beat with no request outstanding: status %0d slot %0d",
                 status, slot);
          fault_count++;
        end else begin
          want = owed_q.pop_front();
          check_field("status",          64'(want.status),    64'(status));
          check_field("slot",            64'(want.slot),      64'(slot));
          check_field("entry_active",    64'(want.active),    64'(entry_active));
          check_field("entry_proc",      64'(want.proc),      64'(entry_proc));
          check_field("entry_thread",    64'(want.thread),    64'(entry_thread));
          check_field("entry_handle",    64'(want.handle),    64'(entry_handle));
          check_field("entry_beat_ns",   64'(want.beat),      64'(entry_beat_ns));
          check_field("entry_wait_addr", want.wait_addr,      entry_wait_addr);
          check_field("entry_gap_ms",    64'(want.gap),       64'(entry_gap_ms));
          check_field("entry_hold_ms",   64'(want.hold),      64'(entry_hold_ms));
        end
      end
      if (start && !busy) begin
        apply_request(req_t'(req_type), proc_id, thread_id, client_handle, stamp_ns,
                      wait_address, gap_limit_ms, hold_limit_ms, slot_select, fresh);
        owed_q.push_back(fresh);
      end
    end
    answers_owed = owed_q.size();
  end

endmodule

### dv/thread_heartbeat_registry_top_tb.sv
// Testbench top for the thread heartbeat registry: clock, reset, directed and
// random request stimulus, and the verdict. Depends on thb_pkg, the registry
// top level and thb_registry_checker.
module thread_heartbeat_registry_top_tb;
  import thb_pkg::*;

  localparam int RAND_ITEMS = 1127;
  localparam int CALM_TAIL  = 150;   // items at the end sent back to back

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [REQ_W-1:0]  req_type;
  logic [PROC_W-1:0] proc_id;
  logic [THR_W-1:0]  thread_id;
  logic [HND_W-1:0]  client_handle;
  logic [BEAT_W-1:0] stamp_ns;
  logic [ADDR_W-1:0] wait_address;
  logic [LIM_W-1:0]  gap_limit_ms;
  logic [LIM_W-1:0]  hold_limit_ms;
  logic [SEL_W-1:0]  slot_select;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [SEL_W-1:0]  slot;
  logic              entry_active;
  logic [PROC_W-1:0] entry_proc;
  logic [THR_W-1:0]  entry_thread;
  logic [HND_W-1:0]  entry_handle;
  logic [BEAT_W-1:0] entry_beat_ns;
  logic [ADDR_W-1:0] entry_wait_addr;
  logic [LIM_W-1:0]  entry_gap_ms;
  logic [LIM_W-1:0]  entry_hold_ms;
  int                fault_count;
  int                answers_owed;

  // Key pools: small enough that requests hit registered threads often, large
  // enough (8 x 32 keys) that add phases run the table into full.
  logic [PROC_W-1:0] proc_pool   [8];
  logic [THR_W-1:0]  thread_pool [32];
  logic [HND_W-1:0]  handle_pool [4];
  // Ring of recently added keys, so updates and removes mostly find a slot.
  logic [PROC_W-1:0] recent_proc   [16];
  logic [THR_W-1:0]  recent_thread [16];
  int                recent_fill;
  int                recent_head;

  thread_heartbeat_registry_top i_dut (.*);

  thb_registry_checker i_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run well beyond the slowest legal completion.
  initial begin
    #20_000_000;
    $display("thread_heartbeat_registry_top_tb: errors");
    $finish;
  end

  // Drive one request beat at the falling edge and hold it until it is taken.
  // Busy only moves at the rising edge, so its value here is the one the next
  // rising edge will see.
  task automatic send(input req_t rq, input logic [PROC_W-1:0] p,
                      input logic [THR_W-1:0] t, input logic [HND_W-1:0] h,
                      input logic [BEAT_W-1:0] stamp, input logic [ADDR_W-1:0] addr,
                      input logic [LIM_W-1:0] gap, input logic [LIM_W-1:0] hold,
                      input logic [SEL_W-1:0] sel);
    logic was_busy;
    @(negedge clk);
    start         <= 1'b1;
    req_type      <= rq;
    proc_id       <= p;
    thread_id     <= t;
    client_handle <= h;
    stamp_ns      <= stamp;
    wait_address  <= addr;
    gap_limit_ms  <= gap;
    hold_limit_ms <= hold;
    slot_select   <= sel;
    was_busy = 1'b1;
    while (was_busy) begin
      was_busy = busy;
      @(posedge clk);
      if (was_busy) @(negedge clk);
    end
  endtask

  // Drop start, wait for the block to go idle, then hold off for a burst.
  task automatic pause(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    while (busy) @(negedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int                n;
    int                mode;
    int                roll;
    int                pick;
    req_t              rq;
    logic [PROC_W-1:0] p;
    logic [THR_W-1:0]  t;
    logic [HND_W-1:0]  h;
    logic [63:0]       wide;
    localparam logic [BEAT_W-1:0] BEAT_MAX = '1;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam logic [LIM_W-1:0]  LIM_MAX  = '1;
    localparam logic [PROC_W-1:0] PROC_MAX = '1;
    localparam logic [THR_W-1:0]  THR_MAX  = '1;
    localparam logic [HND_W-1:0]  HND_MAX  = '1;

    // Hold every input at a known value from time zero.
    rst           = 1'b1;
    start         = 1'b0;
    req_type      = REQ_READ;
    proc_id       = '0;
    thread_id     = '0;
    client_handle = '0;
    stamp_ns      = '0;
    wait_address  = '0;
    gap_limit_ms  = '0;
    hold_limit_ms = '0;
    slot_select   = '0;
    recent_fill   = 0;
    recent_head   = 0;

    proc_pool[0]   = '0;
    proc_pool[1]   = PROC_MAX;
    thread_pool[0] = '0;
    thread_pool[1] = THR_MAX;
    handle_pool[0] = '0;
    handle_pool[1] = HND_MAX;
    for (n = 2; n < 8; n++)  proc_pool[n]   = PROC_W'($urandom);
    for (n = 2; n < 32; n++) thread_pool[n] = THR_W'($urandom);
    for (n = 2; n < 4; n++)  handle_pool[n] = HND_W'($urandom);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, every request kind and the corner cases.
    // read of a free slot returns all-zero entry fields
    send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, 6'd0);
    send(REQ_ADD, '0, '0, '0, BEAT_MAX, ADDR_MAX, '0, LIM_MAX, '0);
    send(REQ_ADD, PROC_MAX, THR_MAX, HND_MAX, '0, '0, LIM_MAX, '0, '1);
    // duplicate add keeps the table and reports the existing slot
    send(REQ_ADD, '0, '0, 16'h5a5a, '0, '0, 32'h1, 32'h2, '0);
    send(REQ_BEAT, '0, '0, '0, BEAT_MAX, '0, '0, '0, '0);
    send(REQ_BEAT, PROC_MAX, THR_MAX, '0, 63'h1, '0, '0, '0, '0);
    send(REQ_WAIT, '0, '0, '0, '0, ADDR_MAX, '0, '0, '0);
    send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, 6'd0);
    send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, 6'd1);
    send(REQ_ACQ, '0, '0, '0, '0, '0, '0, '0, '0);
    send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, 6'd0);
    // unknown key: every keyed update answers not found; then slot 0's thread is removed
    send(REQ_BEAT, 22'h1, 22'h1, '0, BEAT_MAX, '0, '0, '0, '0);
    send(REQ_WAIT, 22'h1, 22'h1, '0, '0, ADDR_MAX, '0, '0, '0);
    send(REQ_ACQ, 22'h1, 22'h1, '0, '0, '0, '0, '0, '0);
    send(REQ_REMOVE, 22'h1, 22'h1, '0, '0, '0, '0, '0, '0);
    send(REQ_REMOVE, '0, '0, '0, '0, '0, '0, '0, '0);
    send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, 6'd0);
    // re-add into the freed slot: heartbeat and wait address start cleared
    send(REQ_ADD, 22'h5, 22'h7, 16'h1234, BEAT_MAX, ADDR_MAX, 32'hdead_beef,
         32'h0bad_f00d, '0);
    send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, 6'd0);
    // cleanups answer ok, with or without a match
    send(REQ_CLEAN_PROC, 22'h123, '0, '0, '0, '0, '0, '0, '0);
    send(REQ_CLEAN_HANDLE, '0, '0, 16'h4321, '0, '0, '0, '0, '0);
    send(REQ_CLEAN_PROC, PROC_MAX, '0, '0, '0, '0, '0, '0, '0);
    send(REQ_ADD, 22'h5, 22'h8, 16'h1234, '0, '0, '0, '0, '0);
    send(REQ_CLEAN_HANDLE, '0, '0, 16'h1234, '0, '0, '0, '0, '0);
    send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, 6'd63);

    // Random part: phases of 120 beats that fill, churn and drain the table.
    for (n = 0; n < RAND_ITEMS; n++) begin
      mode = (n / 120) % 3;
      roll = $urandom_range(0, 99);
      if (mode == 0) begin
        if (roll < 80)      rq = REQ_ADD;
        else if (roll < 86) rq = REQ_BEAT;
        else if (roll < 90) rq = REQ_WAIT;
        else if (roll < 93) rq = REQ_ACQ;
        else                rq = REQ_READ;
      end else if (mode == 1) begin
        if (roll < 30)      rq = REQ_ADD;
        else if (roll < 45) rq = REQ_BEAT;
        else if (roll < 55) rq = REQ_WAIT;
        else if (roll < 63) rq = REQ_ACQ;
        else if (roll < 73) rq = REQ_REMOVE;
        else if (roll < 76) rq = REQ_CLEAN_PROC;
        else if (roll < 79) rq = REQ_CLEAN_HANDLE;
        else                rq = REQ_READ;
      end else begin
        if (roll < 5)       rq = REQ_ADD;
        else if (roll < 12) rq = REQ_BEAT;
        else if (roll < 17) rq = REQ_WAIT;
        else if (roll < 22) rq = REQ_ACQ;
        else if (roll < 62) rq = REQ_REMOVE;
        else if (roll < 70) rq = REQ_CLEAN_PROC;
        else if (roll < 78) rq = REQ_CLEAN_HANDLE;
        else                rq = REQ_READ;
      end

      // Adds mostly take fresh pool keys; everything else mostly aims at a
      // thread added lately. A tenth of the keys are fully random misses.
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        p = PROC_W'($urandom);
        t = THR_W'($urandom);
      end else if (recent_fill > 0 && pick < ((rq == REQ_ADD) ? 25 : 70)) begin
        roll = $urandom_range(0, recent_fill - 1);
        p = recent_proc[roll];
        t = recent_thread[roll];
      end else begin
        p = proc_pool[$urandom_range(0, 7)];
        t = thread_pool[$urandom_range(0, 31)];
      end
      h = ($urandom_range(0, 9) == 0) ? HND_W'($urandom) : handle_pool[$urandom_range(0, 3)];

      if (rq == REQ_ADD) begin
        recent_proc[recent_head]   = p;
        recent_thread[recent_head] = t;
        recent_head = (recent_head + 1) % 16;
        if (recent_fill < 16) recent_fill++;
      end

      // Idle bursts only in alternate stretches of 60 beats, none near the end.
      if (n < RAND_ITEMS - CALM_TAIL && (n / 60) % 2 == 0 && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 14));

      wide = {$urandom, $urandom};
      send(rq, p, t, h, wide[BEAT_W-1:0], {$urandom, $urandom}, $urandom, $urandom,
           SEL_W'($urandom_range(0, 63)));
    end

    // Release start, let every answer come back, then allow some settling time.
    @(negedge clk);
    start <= 1'b0;
    while (answers_owed != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fault_count == 0 && answers_owed == 0) begin
      $display("thread_heartbeat_registry_top_tb: clean");
    end else begin
      $display("thread_heartbeat_registry_top_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
design/thb_pkg.sv
design/thb_ram.sv
design/thb_ctrl.sv
design/thread_heartbeat_registry_top.sv
dv/thb_registry_checker.sv
dv/thread_heartbeat_registry_top_tb.sv
